// ===== rtl/csb_pkg.sv =====
// Shared types, constants and the body base table of the sprite blitter.
`default_nettype none

package csb_pkg;

  // Opcodes of an input word.
  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_HEAD_BASE    = 2'd0;
  localparam logic [1:0] REG_SPRITE_WIDTH = 2'd1;
  localparam logic [1:0] REG_FRAME_INDEX  = 2'd2;

  localparam int CFG_DATA_W = 18;

  // Source rows below this limit come from the head graphics.
  localparam logic [7:0] HEAD_ROWS = 8'd10;
  // Number of body animation frames in use.
  localparam int FRAME_COUNT = 16;

  // Graphics window base added to every source offset.
  localparam logic [18:0] WIN_BASE = 19'h1FFFF;
  // Transparent pixel value.
  localparam logic [7:0] KEY_COLOR = 8'hFF;

  localparam logic [17:0] BODY_BASE [16] = '{
    18'd61628,  18'd61108,  18'd61628,  18'd62108,
    18'd63548,  18'd62588,  18'd63548,  18'd63088,
    18'd183853, 18'd182893, 18'd183853, 18'd183393,
    18'd181933, 18'd181413, 18'd181933, 18'd182413
  };

  typedef struct packed {
    logic [17:0] head_base;
    logic [5:0]  sprite_width;
    logic [3:0]  frame_index;
  } csb_cfg_t;

  typedef struct packed {
    logic        opcode;
    logic [5:0]  clip_width;
    logic [7:0]  clip_height;
    logic [7:0]  dest_col;
    logic [7:0]  src_col;
    logic [7:0]  dest_row;
    logic [7:0]  src_row;
    logic [19:0] dest_base;
    logic [7:0]  dest_stride;
    logic [7:0]  pixel;
  } csb_item_t;

  typedef struct packed {
    logic [18:0] src_addr;
    logic [19:0] dst_addr;
  } csb_start_t;

  typedef struct packed {
    logic        fetch_valid;
    logic [18:0] fetch_addr;
    logic        write_enable;
    logic [19:0] write_addr;
    logic [7:0]  write_data;
    logic        done_res;
  } csb_result_t;

  // Body graphics base for a frame; frames past the last one use the last entry.
  function automatic logic [17:0] body_base(input logic [3:0] frame);
    logic [3:0] f;
    f = (int'(frame) >= FRAME_COUNT) ? 4'(FRAME_COUNT - 1) : frame;
    return BODY_BASE[f];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/csb_addr_gen.sv =====
// First source fetch address and first destination address of a draw.
`default_nettype none

module csb_addr_gen
  import csb_pkg::*;
(
  input  csb_cfg_t   cfg,
  input  csb_item_t  item,
  output csb_start_t start
);

  logic        in_body;
  logic [7:0]  row_sel;
  logic [17:0] src_base;
  logic [13:0] row_prod;
  logic [15:0] dst_prod;
  logic [16:0] dst_cols;

  assign in_body  = (item.src_row >= HEAD_ROWS);
  assign row_sel  = in_body ? (item.src_row - HEAD_ROWS) : item.src_row;
  assign src_base = in_body ? body_base(cfg.frame_index) : cfg.head_base;
  assign row_prod = row_sel * cfg.sprite_width;

  assign start.src_addr = 19'(src_base) + 19'({row_prod, 2'b00})
                        + 19'({item.src_col, 2'b00}) + WIN_BASE;

  assign dst_prod = item.dest_row * item.dest_stride;
  assign dst_cols = 17'(dst_prod) + 17'(item.dest_col);
  assign start.dst_addr = item.dest_base + 20'({dst_cols, 2'b00});

endmodule

`default_nettype wire

// ===== rtl/csb_engine.sv =====
// Draw state and per-word result logic of the sprite blitter.
`default_nettype none

module csb_engine
  import csb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  csb_item_t   item,
  input  csb_cfg_t    cfg,
  output csb_result_t res
);

  logic        busy_r, busy_nxt;
  logic [7:0]  col_r, col_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [7:0]  src_row_r, src_row_nxt;
  logic [18:0] row_src_r, row_src_nxt;
  logic [18:0] cur_src_r, cur_src_nxt;
  logic [19:0] row_dst_r, row_dst_nxt;
  logic [19:0] cur_dst_r, cur_dst_nxt;
  logic [5:0]  geo_cw_r, geo_cw_nxt;
  logic [7:0]  geo_ch_r, geo_ch_nxt;
  logic [7:0]  geo_scol_r, geo_scol_nxt;
  logic [7:0]  geo_stride_r, geo_stride_nxt;

  csb_start_t  start;
  logic [7:0]  col_inc, row_inc, src_row_inc;
  logic [18:0] body_row_addr, step_src_addr;
  logic [19:0] step_dst_addr;

  csb_addr_gen u_addr_gen (
    .cfg   (cfg),
    .item  (item),
    .start (start)
  );

  assign col_inc     = col_r + 8'd1;
  assign row_inc     = row_r + 8'd1;
  assign src_row_inc = (src_row_r == 8'hFF) ? src_row_r : src_row_r + 8'd1;
  assign body_row_addr = 19'(body_base(cfg.frame_index)) + 19'({geo_scol_r, 2'b00}) + WIN_BASE;
  assign step_src_addr = (src_row_inc == HEAD_ROWS) ? body_row_addr
                       : row_src_r + 19'({cfg.sprite_width, 2'b00});
  assign step_dst_addr = row_dst_r + 20'({geo_stride_r, 2'b00});

  always_comb begin
    busy_nxt       = busy_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    src_row_nxt    = src_row_r;
    row_src_nxt    = row_src_r;
    cur_src_nxt    = cur_src_r;
    row_dst_nxt    = row_dst_r;
    cur_dst_nxt    = cur_dst_r;
    geo_cw_nxt     = geo_cw_r;
    geo_ch_nxt     = geo_ch_r;
    geo_scol_nxt   = geo_scol_r;
    geo_stride_nxt = geo_stride_r;
    res            = '0;

    if (item.opcode == OP_START) begin
      geo_cw_nxt     = item.clip_width;
      geo_ch_nxt     = item.clip_height;
      geo_scol_nxt   = item.src_col;
      geo_stride_nxt = item.dest_stride;
      row_src_nxt    = start.src_addr;
      cur_src_nxt    = start.src_addr;
      row_dst_nxt    = start.dst_addr;
      cur_dst_nxt    = start.dst_addr;
      src_row_nxt    = item.src_row;
      col_nxt        = '0;
      row_nxt        = '0;
      if (item.clip_width == '0 || item.clip_height == '0) begin
        busy_nxt     = 1'b0;
        res.done_res = 1'b1;
      end else begin
        busy_nxt        = 1'b1;
        res.fetch_valid = 1'b1;
        res.fetch_addr  = start.src_addr;
      end
    end else if (busy_r) begin
      res.write_addr   = cur_dst_r;
      res.write_data   = item.pixel;
      res.write_enable = (item.pixel != KEY_COLOR);
      if (col_inc >= {geo_cw_r, 2'b00}) begin
        // Last pixel of the row: step both row pointers.
        col_nxt     = '0;
        row_nxt     = row_inc;
        src_row_nxt = src_row_inc;
        row_src_nxt = step_src_addr;
        row_dst_nxt = step_dst_addr;
        cur_src_nxt = step_src_addr;
        cur_dst_nxt = step_dst_addr;
        if (row_inc >= geo_ch_r) begin
          busy_nxt     = 1'b0;
          res.done_res = 1'b1;
        end else begin
          res.fetch_valid = 1'b1;
          res.fetch_addr  = step_src_addr;
        end
      end else begin
        col_nxt         = col_inc;
        cur_src_nxt     = cur_src_r + 19'd1;
        cur_dst_nxt     = cur_dst_r + 20'd1;
        res.fetch_valid = 1'b1;
        res.fetch_addr  = cur_src_r + 19'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      src_row_r    <= '0;
      row_src_r    <= '0;
      cur_src_r    <= '0;
      row_dst_r    <= '0;
      cur_dst_r    <= '0;
      geo_cw_r     <= '0;
      geo_ch_r     <= '0;
      geo_scol_r   <= '0;
      geo_stride_r <= '0;
    end else if (step_en) begin
      busy_r       <= busy_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      src_row_r    <= src_row_nxt;
      row_src_r    <= row_src_nxt;
      cur_src_r    <= cur_src_nxt;
      row_dst_r    <= row_dst_nxt;
      cur_dst_r    <= cur_dst_nxt;
      geo_cw_r     <= geo_cw_nxt;
      geo_ch_r     <= geo_ch_nxt;
      geo_scol_r   <= geo_scol_nxt;
      geo_stride_r <= geo_stride_nxt;
    end
  end

  a_fetch_or_done: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |-> !(res.fetch_valid && res.done_res))
    else $error("fetch and done reported in the same result");

  a_key_not_written: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.write_enable |-> res.write_data != KEY_COLOR)
    else $error("transparent pixel written");

  a_done_ends_draw: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.done_res |=> !busy_r)
    else $error("draw still busy after done");

  a_fetch_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.fetch_valid |=> busy_r)
    else $error("fetch issued but draw not busy");

  a_idle_pixel_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.opcode == OP_PIXEL && !busy_r |-> res == '0)
    else $error("pixel while idle gave a non-empty result");

endmodule

`default_nettype wire

// ===== rtl/clipped_sprite_blit_color_key.sv =====
// Top level of the clipped sprite blitter with color key.
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    opcode, geometry fields, pixel
// out_      output     out_valid / out_stall  fetch, write and done fields
// cfg_      input      cfg_write_en           cfg_index, cfg_data
//
// Every input word gives exactly one result word. A word is held in an input
// register and its result is registered in the output register when the word
// advances. The block takes one word per cycle while out_stall is low, and
// the draw counters update once per word.
// Reset is synchronous and active low; it clears the draw state, the
// configuration registers and both valid flags.
// A stall on the output holds the result and backs up into in_stall, which
// is high only while the input register is full and cannot move on.

module clipped_sprite_blit_color_key
  import csb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_opcode,
  input  wire logic [5:0]            in_clip_width,
  input  wire logic [7:0]            in_clip_height,
  input  wire logic [7:0]            in_dest_col,
  input  wire logic [7:0]            in_src_col,
  input  wire logic [7:0]            in_dest_row,
  input  wire logic [7:0]            in_src_row,
  input  wire logic [19:0]           in_dest_base,
  input  wire logic [7:0]            in_dest_stride,
  input  wire logic [7:0]            in_pixel,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_fetch_valid,
  output logic [18:0]                out_fetch_addr,
  output logic                       out_write_enable,
  output logic [19:0]                out_write_addr,
  output logic [7:0]                 out_write_data,
  output logic                       out_done_res,

  input  wire logic                  cfg_write_en,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  csb_cfg_t    cfg_r;
  csb_item_t   item_r;
  logic        item_valid_r;
  csb_result_t res;
  csb_result_t res_r;
  logic        out_valid_r;
  logic        advance;
  logic        in_take;

  // The held word moves on whenever the output register is free or draining.
  assign advance  = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers. The user writes them only while no word is in
  // flight (not enforced by the block); an open draw then uses the new values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_HEAD_BASE:    cfg_r.head_base    <= cfg_data[17:0];
        REG_SPRITE_WIDTH: cfg_r.sprite_width <= cfg_data[5:0];
        REG_FRAME_INDEX:  cfg_r.frame_index  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode      <= in_opcode;
      item_r.clip_width  <= in_clip_width;
      item_r.clip_height <= in_clip_height;
      item_r.dest_col    <= in_dest_col;
      item_r.src_col     <= in_src_col;
      item_r.dest_row    <= in_dest_row;
      item_r.src_row     <= in_src_row;
      item_r.dest_base   <= in_dest_base;
      item_r.dest_stride <= in_dest_stride;
      item_r.pixel       <= in_pixel;
    end
  end

  // Draw state and result logic; it steps once for each word that advances.
  csb_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fetch_valid  = res_r.fetch_valid;
  assign out_fetch_addr   = res_r.fetch_addr;
  assign out_write_enable = res_r.write_enable;
  assign out_write_addr   = res_r.write_addr;
  assign out_write_data   = res_r.write_data;
  assign out_done_res     = res_r.done_res;

endmodule

`default_nettype wire
